/* design/imd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMD parser package
// Shared types, record codes and format constants for the IMD stream parser.
// ----------------------------------------------------------------------------
package imd_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_COMMENT,
    PH_MODE,
    PH_CYL,
    PH_HEAD,
    PH_COUNT,
    PH_KEY,
    PH_ORDER,
    PH_CYLMAP,
    PH_HEADMAP,
    PH_TYPE,
    PH_FILL,
    PH_DATA,
    PH_HALT
  } phase_t;

  // Record kinds
  localparam logic [2:0] REC_TRACK  = 3'd0;
  localparam logic [2:0] REC_SECTOR = 3'd1;
  localparam logic [2:0] REC_DATA   = 3'd2;
  localparam logic [2:0] REC_FILL   = 3'd3;
  localparam logic [2:0] REC_ERROR  = 3'd4;

  // Error codes
  localparam logic ERR_SIZE_KEY    = 1'b0;
  localparam logic ERR_SECTOR_TYPE = 1'b1;

  // Format constants
  localparam logic [7:0]  COMMENT_END     = 8'h1A;
  localparam int          HEAD_CYLMAP_BIT = 7;   // 0x80
  localparam int          HEAD_HDMAP_BIT  = 6;   // 0x40
  localparam logic [7:0]  KEY_HARD_LIMIT  = 8'd7;
  localparam logic [7:0]  TYPE_MAX        = 8'd8;
  localparam logic [7:0]  TYPE_NO_DATA    = 8'd0;
  localparam int          TYPE_FILL_BIT   = 0;   // 0x01 of type - 1
  localparam int          TYPE_DEL_BIT    = 1;   // 0x02
  localparam int          TYPE_ERR_BIT    = 2;   // 0x04
  localparam logic [13:0] SECTOR_BASE     = 14'd128;

  // Mode decode
  localparam logic [7:0]  MODE_MFM_LO     = 8'd3;
  localparam logic [7:0]  MODE_MFM_HI     = 8'd5;
  localparam logic [1:0]  RATE_UNKNOWN    = 2'd3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } imd_in_t;

  typedef struct packed {
    logic [2:0] rec_kind;
    logic       double_density;
    logic [1:0] rate_code;
    logic [7:0] cylinder;
    logic       head_side;
    logic [7:0] sector_count;
    logic [2:0] size_key;
    logic [7:0] sector_id;
    logic       deleted_mark;
    logic       data_error;
    logic [7:0] byte_value;
    logic       error_code;
  } imd_out_t;

  // Classified record handed from front to back
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] mode;
    logic [7:0] cyl;
    logic       head;
    logic [7:0] count;
    logic [2:0] key;
    logic [7:0] sector_id;
    logic       deleted;
    logic       data_err;
    logic [7:0] value;
    logic       err_code;
  } cmd_t;

endpackage
`default_nettype wire

/* design/imd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMD parser front end
// Walks the image byte stream, holds track state and the sector numbering
// map, and emits one classified command per record-producing byte.
// ----------------------------------------------------------------------------
module imd_front #(
  parameter int MAX_SECTORS    = 256,
  parameter int SIZE_KEY_LIMIT = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire imd_pkg::imd_in_t item,
  output logic                  cmd_valid,
  output imd_pkg::cmd_t         cmd
);

  localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

  imd_pkg::phase_t phase, phase_next;
  logic [7:0]  mode_reg, mode_reg_next;
  logic [7:0]  cyl_reg, cyl_reg_next;
  logic        head_reg, head_reg_next;
  logic        cyl_map_present, cyl_map_present_next;
  logic        head_map_present, head_map_present_next;
  logic [7:0]  count_reg, count_reg_next;
  logic [2:0]  key_reg, key_reg_next;
  logic [7:0]  sector_index, sector_index_next;
  logic [12:0] byte_index, byte_index_next;
  logic [7:0]  cur_id;

  logic [7:0] order_map [MAX_SECTORS];

  logic [7:0]  b;
  logic [7:0]  t;
  logic [7:0]  si_inc;
  logic        si_done;
  logic [12:0] bi_inc;
  logic        bi_done;
  logic        key_bad;
  logic        map_we;
  logic        wr_in_range;
  logic        rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign b       = item.file_byte;
  assign t       = b - 8'd1;
  assign si_inc  = sector_index + 8'd1;
  assign si_done = (si_inc >= count_reg) || (si_inc == 8'd0);
  assign bi_inc  = byte_index + 13'd1;
  assign bi_done = ({1'b0, bi_inc} >= (imd_pkg::SECTOR_BASE << key_reg)) ||
                   (bi_inc == 13'd0);
  assign key_bad = (b >= 8'(SIZE_KEY_LIMIT)) || (b >= imd_pkg::KEY_HARD_LIMIT);

  // Next state
  always_comb begin
    phase_next            = phase;
    mode_reg_next         = mode_reg;
    cyl_reg_next          = cyl_reg;
    head_reg_next         = head_reg;
    cyl_map_present_next  = cyl_map_present;
    head_map_present_next = head_map_present;
    count_reg_next        = count_reg;
    key_reg_next          = key_reg;
    sector_index_next     = sector_index;
    byte_index_next       = byte_index;
    if (take) begin
      if (item.start_of_file) begin
        mode_reg_next         = '0;
        cyl_reg_next          = '0;
        head_reg_next         = 1'b0;
        cyl_map_present_next  = 1'b0;
        head_map_present_next = 1'b0;
        count_reg_next        = '0;
        key_reg_next          = '0;
        sector_index_next     = '0;
        byte_index_next       = '0;
        phase_next = (b == imd_pkg::COMMENT_END) ? imd_pkg::PH_MODE : imd_pkg::PH_COMMENT;
      end else begin
        unique case (phase)
          imd_pkg::PH_COMMENT: begin
            if (b == imd_pkg::COMMENT_END) phase_next = imd_pkg::PH_MODE;
          end
          imd_pkg::PH_MODE: begin
            mode_reg_next = b;
            phase_next    = imd_pkg::PH_CYL;
          end
          imd_pkg::PH_CYL: begin
            cyl_reg_next = b;
            phase_next   = imd_pkg::PH_HEAD;
          end
          imd_pkg::PH_HEAD: begin
            cyl_map_present_next  = b[imd_pkg::HEAD_CYLMAP_BIT];
            head_map_present_next = b[imd_pkg::HEAD_HDMAP_BIT];
            head_reg_next         = b[0];
            phase_next            = imd_pkg::PH_COUNT;
          end
          imd_pkg::PH_COUNT: begin
            count_reg_next = b;
            phase_next     = imd_pkg::PH_KEY;
          end
          imd_pkg::PH_KEY: begin
            if (key_bad) begin
              phase_next = imd_pkg::PH_HALT;
            end else begin
              key_reg_next      = b[2:0];
              sector_index_next = '0;
              phase_next = (count_reg == 8'd0) ? imd_pkg::PH_MODE : imd_pkg::PH_ORDER;
            end
          end
          imd_pkg::PH_ORDER: begin
            sector_index_next = si_inc;
            if (si_done) begin
              sector_index_next = '0;
              priority if (cyl_map_present)  phase_next = imd_pkg::PH_CYLMAP;
              else if (head_map_present)     phase_next = imd_pkg::PH_HEADMAP;
              else                           phase_next = imd_pkg::PH_TYPE;
            end
          end
          imd_pkg::PH_CYLMAP: begin
            sector_index_next = si_inc;
            if (si_done) begin
              sector_index_next = '0;
              phase_next = head_map_present ? imd_pkg::PH_HEADMAP : imd_pkg::PH_TYPE;
            end
          end
          imd_pkg::PH_HEADMAP: begin
            sector_index_next = si_inc;
            if (si_done) begin
              sector_index_next = '0;
              phase_next        = imd_pkg::PH_TYPE;
            end
          end
          imd_pkg::PH_TYPE: begin
            priority if (b == imd_pkg::TYPE_NO_DATA) begin
              sector_index_next = si_inc;
              phase_next = si_done ? imd_pkg::PH_MODE : imd_pkg::PH_TYPE;
            end else if (b > imd_pkg::TYPE_MAX) begin
              phase_next = imd_pkg::PH_HALT;
            end else begin
              byte_index_next = '0;
              phase_next = t[imd_pkg::TYPE_FILL_BIT] ? imd_pkg::PH_FILL : imd_pkg::PH_DATA;
            end
          end
          imd_pkg::PH_FILL: begin
            sector_index_next = si_inc;
            phase_next = si_done ? imd_pkg::PH_MODE : imd_pkg::PH_TYPE;
          end
          imd_pkg::PH_DATA: begin
            byte_index_next = bi_inc;
            if (bi_done) begin
              sector_index_next = si_inc;
              phase_next = si_done ? imd_pkg::PH_MODE : imd_pkg::PH_TYPE;
            end
          end
          imd_pkg::PH_HALT: begin
          end
          default: begin
            phase_next = imd_pkg::PH_HALT;
          end
        endcase
      end
    end
  end

  // Command outputs
  always_comb begin
    cmd_valid     = 1'b0;
    cmd.kind      = imd_pkg::REC_TRACK;
    cmd.mode      = mode_reg;
    cmd.cyl       = cyl_reg;
    cmd.head      = head_reg;
    cmd.count     = count_reg;
    cmd.key       = key_reg;
    cmd.sector_id = cur_id;
    cmd.deleted   = t[imd_pkg::TYPE_DEL_BIT];
    cmd.data_err  = t[imd_pkg::TYPE_ERR_BIT];
    cmd.value     = b;
    cmd.err_code  = imd_pkg::ERR_SIZE_KEY;
    if (take && !item.start_of_file) begin
      unique case (phase)
        imd_pkg::PH_KEY: begin
          cmd_valid = 1'b1;
          cmd.key   = b[2:0];
          cmd.kind  = key_bad ? imd_pkg::REC_ERROR : imd_pkg::REC_TRACK;
        end
        imd_pkg::PH_TYPE: begin
          cmd_valid = (b != imd_pkg::TYPE_NO_DATA);
          if (b > imd_pkg::TYPE_MAX) begin
            cmd.kind     = imd_pkg::REC_ERROR;
            cmd.err_code = imd_pkg::ERR_SECTOR_TYPE;
          end else begin
            cmd.kind = imd_pkg::REC_SECTOR;
          end
        end
        imd_pkg::PH_FILL: begin
          cmd_valid = 1'b1;
          cmd.kind  = imd_pkg::REC_FILL;
        end
        imd_pkg::PH_DATA: begin
          cmd_valid = 1'b1;
          cmd.kind  = imd_pkg::REC_DATA;
        end
        default: begin
          cmd_valid = 1'b0;
        end
      endcase
    end
  end

  // Numbering map: one write port, one registered read port that tracks the
  // sector index, with write-through for a same-cycle write.
  assign wr_in_range = ({1'b0, sector_index} < 9'(MAX_SECTORS));
  assign rd_in_range = ({1'b0, sector_index_next} < 9'(MAX_SECTORS));
  assign wr_addr     = AW'(sector_index);
  assign rd_addr     = AW'(sector_index_next);
  assign map_we      = take && !item.start_of_file &&
                       (phase == imd_pkg::PH_ORDER) && wr_in_range;

  always_ff @(posedge clk) begin
    if (map_we) order_map[wr_addr] <= b;
    if (!rd_in_range)                        cur_id <= '0;
    else if (map_we && (wr_addr == rd_addr)) cur_id <= b;
    else                                     cur_id <= order_map[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= imd_pkg::PH_COMMENT;
      mode_reg         <= '0;
      cyl_reg          <= '0;
      head_reg         <= 1'b0;
      cyl_map_present  <= 1'b0;
      head_map_present <= 1'b0;
      count_reg        <= '0;
      key_reg          <= '0;
      sector_index     <= '0;
      byte_index       <= '0;
    end else begin
      phase            <= phase_next;
      mode_reg         <= mode_reg_next;
      cyl_reg          <= cyl_reg_next;
      head_reg         <= head_reg_next;
      cyl_map_present  <= cyl_map_present_next;
      head_map_present <= head_map_present_next;
      count_reg        <= count_reg_next;
      key_reg          <= key_reg_next;
      sector_index     <= sector_index_next;
      byte_index       <= byte_index_next;
    end
  end

endmodule
`default_nettype wire

/* design/imd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMD command queue
// Short FIFO of classified commands between parser front and back end.
// ----------------------------------------------------------------------------
module imd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire imd_pkg::cmd_t push_data,
  output logic               has_space,
  input  wire logic          pop,
  output logic               not_empty,
  output imd_pkg::cmd_t      head_data
);

  localparam logic [imd_pkg::QUEUE_PW-1:0] LAST_PTR =
    imd_pkg::QUEUE_PW'(imd_pkg::QUEUE_DEPTH - 1);
  localparam logic [imd_pkg::QUEUE_CW-1:0] FULL_COUNT =
    imd_pkg::QUEUE_CW'(imd_pkg::QUEUE_DEPTH);

  imd_pkg::cmd_t slots [imd_pkg::QUEUE_DEPTH];
  logic [imd_pkg::QUEUE_PW-1:0] wr_ptr, rd_ptr;
  logic [imd_pkg::QUEUE_CW-1:0] fill;
  logic do_push, do_pop;

  assign has_space = (fill != FULL_COUNT);
  assign not_empty = (fill != '0);
  assign do_push   = push && has_space;
  assign do_pop    = pop && not_empty;
  assign head_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/imd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMD parser back end
// Decodes the mode byte, masks unused fields per record kind and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module imd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire imd_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               rec_valid,
  input  wire logic          rec_ready,
  output imd_pkg::imd_out_t  rec_item
);

  imd_pkg::imd_out_t fmt;
  logic              dd;
  logic [1:0]        rate;
  logic              has_track, has_id, has_flags, has_value, is_error;

  assign cmd_pop = cmd_valid && (!rec_valid || rec_ready);

  assign dd = (cmd.mode >= imd_pkg::MODE_MFM_LO) && (cmd.mode <= imd_pkg::MODE_MFM_HI);

  always_comb begin
    unique case (cmd.mode)
      8'd0, 8'd3: rate = 2'd0;
      8'd1, 8'd4: rate = 2'd1;
      8'd2, 8'd5: rate = 2'd2;
      default:    rate = imd_pkg::RATE_UNKNOWN;
    endcase
  end

  assign is_error  = (cmd.kind == imd_pkg::REC_ERROR);
  assign has_track = !is_error;
  assign has_id    = (cmd.kind == imd_pkg::REC_SECTOR) || (cmd.kind == imd_pkg::REC_DATA) ||
                     (cmd.kind == imd_pkg::REC_FILL);
  assign has_flags = (cmd.kind == imd_pkg::REC_SECTOR);
  assign has_value = (cmd.kind == imd_pkg::REC_DATA) || (cmd.kind == imd_pkg::REC_FILL);

  always_comb begin
    fmt                = '0;
    fmt.rec_kind       = cmd.kind;
    if (has_track) begin
      fmt.double_density = dd;
      fmt.rate_code      = rate;
      fmt.cylinder       = cmd.cyl;
      fmt.head_side      = cmd.head;
      fmt.sector_count   = cmd.count;
      fmt.size_key       = cmd.key;
    end
    if (has_id)    fmt.sector_id    = cmd.sector_id;
    if (has_flags) begin
      fmt.deleted_mark = cmd.deleted;
      fmt.data_error   = cmd.data_err;
    end
    if (has_value) fmt.byte_value   = cmd.value;
    if (is_error)  fmt.error_code   = cmd.err_code;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) rec_item <= fmt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (cmd_pop) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* design/imd_disk_image_stream_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMD disk image stream parser
// Byte-stream parser for ImageDisk images: track headers, sector headers,
// data bytes, fill records and error records.
// ----------------------------------------------------------------------------
// byte channel (byte_valid/byte_ready/byte_item): one image byte per
//   transaction; start_of_file restarts parsing with that byte as the first
//   of a new image. rec channel (rec_valid/rec_ready/rec_item): zero or one
//   record per byte, in byte order, unused fields zero.
// Throughput: one byte per cycle when not stalled; the numbering map read
//   port tracks the sector index, so the entry is ready before the type byte.
// Path: a command enters the queue at its byte's accepting edge and moves to
//   the output register when that register is free or being emptied;
//   rec_item is registered and rec_valid rises once the command is in it.
// Stall: byte_ready is low while both queue entries are taken; bytes are
//   taken again once a record leaves the queue.
// Reset: clears the parser to comment skip and empties queue and output;
//   the numbering map is not cleared. After a bad size key or sector type
//   one error record is given and bytes are swallowed until start_of_file.
// ----------------------------------------------------------------------------
module imd_disk_image_stream_parser #(
  parameter int MAX_SECTORS    = 256,
  parameter int SIZE_KEY_LIMIT = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire imd_pkg::imd_in_t  byte_item,
  output logic                   rec_valid,
  input  wire logic              rec_ready,
  output imd_pkg::imd_out_t      rec_item
);

  logic          take;
  logic          cmd_valid;
  imd_pkg::cmd_t cmd;
  logic          q_has_space;
  logic          q_not_empty;
  logic          q_pop;
  imd_pkg::cmd_t q_head;

  // A byte is taken whenever the queue has a free slot, whether or not it
  // produces a record; this keeps byte_ready a pure register decode.
  assign byte_ready = q_has_space;
  assign take       = byte_valid && byte_ready;

  imd_front #(
    .MAX_SECTORS    (MAX_SECTORS),
    .SIZE_KEY_LIMIT (SIZE_KEY_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (byte_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  imd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_valid),
    .push_data (cmd),
    .has_space (q_has_space),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  imd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec_item  (rec_item)
  );

endmodule
`default_nettype wire
